@@ src/rau_pkg.sv @@
// Shared widths, command codes and controller/datapath link types
// for the rational arithmetic unit. No dependencies.
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int PROD_W        = 2 * OPERAND_WIDTH;
    localparam int RES_W         = 2 * OPERAND_WIDTH + 1;
    localparam int SHIFT_W       = $clog2(RES_W + 1);
    localparam int DIV_CNT_W     = $clog2(RES_W);
    localparam int CMD_W         = 3;

    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LESS    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_GREATER = 3'd5;
    localparam logic [CMD_W-1:0] CMD_EQUAL   = 3'd6;

    // product register selects
    localparam logic [1:0] MUL_LEFT  = 2'd0;  // a_num * b_den
    localparam logic [1:0] MUL_RIGHT = 2'd1;  // a_den * b_num
    localparam logic [1:0] MUL_DEN   = 2'd2;  // a_den * b_den
    localparam logic [1:0] MUL_NUM   = 2'd3;  // a_num * b_num

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       form;
        logic       gcd_init;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_write;
    } t_dp_ctrl;

    typedef struct packed {
        logic arith;
        logic den_zero;
        logic gcd_done;
        logic out_free;
    } t_dp_stat;

endpackage

@@ src/rau_op_if.sv @@
// Input channel of the rational arithmetic unit: command and two fractions.
// Depends on rau_pkg.
interface rau_op_if;
    import rau_pkg::*;

    logic                            valid;
    logic                            ready;
    logic [CMD_W-1:0]                command;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;

    modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

@@ src/rau_res_if.sv @@
// Result channel of the rational arithmetic unit.
// Depends on rau_pkg.
interface rau_res_if;
    import rau_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] res_num;
    logic signed [RES_W-1:0] res_den;
    logic                    cmp_true;
    logic                    zero_error;

    modport source (output valid, res_num, res_den, cmp_true, zero_error, input ready);
    modport sink   (input valid, res_num, res_den, cmp_true, zero_error, output ready);
endinterface

@@ src/rational_arithmetic_unit_core.sv @@
// Rational arithmetic unit: add, subtract, multiply, divide and compare two
// 16-bit fractions, arithmetic results reduced to lowest terms with the
// denominator nonnegative. One item is worked on at a time. For compares and
// results with a zero denominator the input is ready again after four passes
// through the single shared multiplier, forming the raw fraction, checking it
// and writing the result register. Other arithmetic results, between check
// and write, also take binary gcd steps (one subtract-and-shift per cycle),
// latching of the gcd and bit-serial division of numerator and denominator
// by it. The write cycle waits while the result register still holds an
// unaccepted beat; that register lets the next item enter while a finished
// beat waits. Depends on rau_pkg, rau_op_if, rau_res_if, rau_ctrl, rau_datapath.
module rational_arithmetic_unit_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_op_if.sink    i_op,
    rau_res_if.source o_res
);
    import rau_pkg::*;

    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_op.ready = w_in_ready;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_op.valid),
        .o_in_ready (w_in_ready),
        .o_ctrl     (w_ctrl),
        .i_stat     (w_stat)
    );

    rau_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (i_op),
        .o_res   (o_res),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat)
    );

endmodule

@@ src/rau_ctrl.sv @@
// Sequencer for the rational arithmetic unit: steps the datapath through
// multiply, form, binary gcd, division and result write. Depends on rau_pkg.
module rau_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output rau_pkg::t_dp_ctrl   o_ctrl,
    input  rau_pkg::t_dp_stat   i_stat
);
    import rau_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_FORM  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_GCD   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_WRITE = 7'b1000000
    } t_state;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ctrl  = '0;
        o_ctrl.mul_sel = r_cnt[1:0];
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                o_ctrl.mul_en = 1'b1;
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt[1:0] == MUL_NUM) begin
                    n_state = S_FORM;
                end
            end
            S_FORM: begin
                o_ctrl.form = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                // compares and x/0 need no reduction
                if (!i_stat.arith || i_stat.den_zero) begin
                    n_state = S_WRITE;
                end else begin
                    o_ctrl.gcd_init = 1'b1;
                    n_state         = S_GCD;
                end
            end
            S_GCD: begin
                if (i_stat.gcd_done) begin
                    o_ctrl.div_init = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_DIV;
                end else begin
                    o_ctrl.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                o_ctrl.div_step = 1'b1;
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(RES_W - 1)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (i_stat.out_free) begin
                    o_ctrl.out_write = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_no_step_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.gcd_step |-> !i_stat.gcd_done)
        else $error("gcd step issued after gcd finished");

    a_div_after_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.div_init |-> i_stat.gcd_done)
        else $error("division started before gcd finished");

    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.out_write |-> i_stat.out_free)
        else $error("result written over a pending beat");

endmodule

@@ src/rau_datapath.sv @@
// Datapath of the rational arithmetic unit: operand registers, shared
// multiplier, binary gcd, two-lane restoring divider, result register. Uses rau_pkg.
module rau_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rau_op_if.sink              i_op,
    rau_res_if.source           o_res,
    input  rau_pkg::t_dp_ctrl   i_ctrl,
    output rau_pkg::t_dp_stat   o_stat
);
    import rau_pkg::*;

    logic [CMD_W-1:0]                r_cmd;
    logic signed [OPERAND_WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [PROD_W-1:0]        r_pl, r_pr, r_pd, r_pn;
    logic signed [RES_W-1:0]         r_num, r_den;
    logic                            r_neg, r_cmp, r_arith, r_den_zero, r_num_zero;
    logic [RES_W-1:0]                r_u, r_v, r_g;
    logic [SHIFT_W-1:0]              r_k;
    logic [RES_W-1:0]                r_rem_n, r_rem_d, r_qn, r_qd;
    logic                            r_out_valid;
    logic signed [RES_W-1:0]         r_res_num, r_res_den;
    logic                            r_res_cmp, r_res_err;

    // shared multiplier
    logic signed [OPERAND_WIDTH-1:0] w_mx, w_my;
    logic signed [PROD_W-1:0]        w_prod;

    always_comb begin
        case (i_ctrl.mul_sel)
            MUL_LEFT:  begin w_mx = r_an; w_my = r_bd; end
            MUL_RIGHT: begin w_mx = r_ad; w_my = r_bn; end
            MUL_DEN:   begin w_mx = r_ad; w_my = r_bd; end
            MUL_NUM:   begin w_mx = r_an; w_my = r_bn; end
            default:   begin w_mx = r_an; w_my = r_bn; end
        endcase
    end

    assign w_prod = w_mx * w_my;

    // raw fraction from cross products
    logic signed [RES_W-1:0] w_l, w_r, w_d, w_n, w_fnum, w_fden;
    logic                    w_fcmp;

    assign w_l = {r_pl[PROD_W-1], r_pl};
    assign w_r = {r_pr[PROD_W-1], r_pr};
    assign w_d = {r_pd[PROD_W-1], r_pd};
    assign w_n = {r_pn[PROD_W-1], r_pn};

    always_comb begin
        w_fnum = w_l;
        w_fden = w_r;
        w_fcmp = 1'b0;
        case (r_cmd)
            CMD_ADD:     begin w_fnum = w_l + w_r; w_fden = w_d; end
            CMD_SUB:     begin w_fnum = w_l - w_r; w_fden = w_d; end
            CMD_MUL:     begin w_fnum = w_n;       w_fden = w_d; end
            CMD_DIV:     begin w_fnum = w_l;       w_fden = w_r; end
            CMD_LESS:    w_fcmp = (r_pl < r_pr);
            CMD_GREATER: w_fcmp = (r_pl > r_pr);
            CMD_EQUAL:   w_fcmp = (r_pl == r_pr);
            default:     w_fcmp = 1'b0;
        endcase
    end

    // magnitudes
    logic [RES_W-1:0] w_num_u, w_den_u, w_num_mag, w_den_mag;

    assign w_num_u   = r_num;
    assign w_den_u   = r_den;
    assign w_num_mag = w_num_u[RES_W-1] ? (~w_num_u + RES_W'(1)) : w_num_u;
    assign w_den_mag = w_den_u[RES_W-1] ? (~w_den_u + RES_W'(1)) : w_den_u;

    // binary gcd step
    logic             w_u_even, w_v_even, w_ge, w_gcd_done;
    logic [RES_W-1:0] w_diff;

    assign w_u_even   = !r_u[0];
    assign w_v_even   = !r_v[0];
    assign w_ge       = (r_u >= r_v);
    assign w_diff     = w_ge ? (r_u - r_v) : (r_v - r_u);
    assign w_gcd_done = (r_u == '0) || (r_v == '0);

    // restoring divider, numerator and denominator lanes share the divisor
    logic [RES_W:0]   w_tn, w_td, w_tn_sub, w_td_sub;
    logic             w_bn, w_bd;

    assign w_tn     = {r_rem_n, r_qn[RES_W-1]};
    assign w_td     = {r_rem_d, r_qd[RES_W-1]};
    assign w_tn_sub = w_tn - {1'b0, r_g};
    assign w_td_sub = w_td - {1'b0, r_g};
    assign w_bn     = (w_tn >= {1'b0, r_g});
    assign w_bd     = (w_td >= {1'b0, r_g});

    // result assembly
    logic signed [RES_W-1:0] w_onum, w_oden;
    logic                    w_ocmp, w_oerr;
    logic [RES_W-1:0]        w_qn_neg;

    assign w_qn_neg = ~r_qn + RES_W'(1);

    always_comb begin
        w_onum = '0;
        w_oden = '0;
        w_ocmp = 1'b0;
        w_oerr = 1'b0;
        if (!r_arith) begin
            w_ocmp = r_cmp;
        end else if (r_den_zero && r_num_zero) begin
            w_oerr = 1'b1;
        end else if (r_den_zero) begin
            w_onum = RES_W'(1);
        end else begin
            w_onum = r_neg ? w_qn_neg : r_qn;
            w_oden = r_qd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_op.command;
            r_an  <= i_op.a_num;
            r_ad  <= i_op.a_den;
            r_bn  <= i_op.b_num;
            r_bd  <= i_op.b_den;
        end
        if (i_ctrl.mul_en) begin
            case (i_ctrl.mul_sel)
                MUL_LEFT:  r_pl <= w_prod;
                MUL_RIGHT: r_pr <= w_prod;
                MUL_DEN:   r_pd <= w_prod;
                MUL_NUM:   r_pn <= w_prod;
                default:   r_pn <= w_prod;
            endcase
        end
        if (i_ctrl.form) begin
            r_num      <= w_fnum;
            r_den      <= w_fden;
            r_neg      <= w_fnum[RES_W-1] ^ w_fden[RES_W-1];
            r_cmp      <= w_fcmp;
            r_arith    <= !r_cmd[CMD_W-1];
            r_den_zero <= (w_fden == '0);
            r_num_zero <= (w_fnum == '0);
        end
        if (i_ctrl.gcd_init) begin
            r_u <= w_num_mag;
            r_v <= w_den_mag;
            r_k <= '0;
        end else if (i_ctrl.gcd_step) begin
            if (w_u_even && w_v_even) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + SHIFT_W'(1);
            end else if (w_u_even) begin
                r_u <= r_u >> 1;
            end else if (w_v_even) begin
                r_v <= r_v >> 1;
            end else if (w_ge) begin
                r_u <= w_diff >> 1;
            end else begin
                r_v <= w_diff >> 1;
            end
        end
        if (i_ctrl.div_init) begin
            r_g     <= (r_u | r_v) << r_k;
            r_qn    <= w_num_mag;
            r_qd    <= w_den_mag;
            r_rem_n <= '0;
            r_rem_d <= '0;
        end else if (i_ctrl.div_step) begin
            r_rem_n <= w_bn ? w_tn_sub[RES_W-1:0] : w_tn[RES_W-1:0];
            r_rem_d <= w_bd ? w_td_sub[RES_W-1:0] : w_td[RES_W-1:0];
            r_qn    <= {r_qn[RES_W-2:0], w_bn};
            r_qd    <= {r_qd[RES_W-2:0], w_bd};
        end
        if (i_ctrl.out_write) begin
            r_res_num <= w_onum;
            r_res_den <= w_oden;
            r_res_cmp <= w_ocmp;
            r_res_err <= w_oerr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_write) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.res_num    = r_res_num;
    assign o_res.res_den    = r_res_den;
    assign o_res.cmp_true   = r_res_cmp;
    assign o_res.zero_error = r_res_err;

    assign o_stat.arith    = r_arith;
    assign o_stat.den_zero = r_den_zero;
    assign o_stat.gcd_done = w_gcd_done;
    assign o_stat.out_free = !r_out_valid || o_res.ready;

    a_err_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.zero_error) |->
            (o_res.res_num == '0) && (o_res.res_den == '0) && !o_res.cmp_true)
        else $error("zero_error beat carries a nonzero fraction");

    a_den_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !o_res.res_den[RES_W-1])
        else $error("negative denominator in result beat");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.div_init |=> (r_g != '0))
        else $error("gcd came out zero");

endmodule
